// ===== rtl/sfs_pkg.sv =====
package sfs_pkg;

   localparam int CMD_W    = 16;
   localparam int SAMPLE_W = 12;
   localparam int CHAN_W   = 4;
   localparam int GPIO_W   = 4;
   localparam int REQ_W    = 32;
   localparam int RSP_W    = 16;

   localparam logic [3:0] CODE_CONTINUE = 4'h0;
   localparam logic [3:0] CODE_MANUAL   = 4'h1;
   localparam logic [3:0] CODE_AUTO1    = 4'h2;
   localparam logic [3:0] CODE_AUTO2    = 4'h3;
   localparam logic [3:0] CODE_PROG1    = 4'h8;
   localparam logic [3:0] CODE_PROG2    = 4'h9;

   localparam logic [1:0] MODE_MANUAL = 2'd1;
   localparam logic [1:0] MODE_AUTO2  = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [CMD_W-1:0]    command;
   } req_word_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] reading;
      logic [CHAN_W-1:0]   tag;
      logic                bad_command;
   } rsp_word_type;

   typedef struct packed {
      logic reset_channel;
      logic gpio_out;
   } flags_type;

endpackage

// ===== rtl/spi_adc_frame_sequencer_top.sv =====
// spi adc frame sequencer
// req channel: one word per spi frame, the command frame and the conversion
//   value of the channel that goes out in that frame
// rsp channel: one word per req word, the tag (sent channel or gpio levels),
//   the reading, and a bad-command flag in tuser that zeroes tag and reading
// csr port: csr_we loads the four gpio levels, write only while idle
// an accepted word sits in the input register until the core takes it,
//   which it does once the result register is empty or rsp_tready is high;
//   its result is then registered and rsp_tvalid rises
// throughput: one word per cycle while rsp_tready is high, set by the single
//   pass of the sequencer logic between the input and the result register
// reset clears the valid bits of both registers, the channel pipeline,
//   the mode (manual), the settings flags, the end channel and the gpio levels
// when the receiver stalls the result is held, the input register still
//   takes one more word, and then req_tready falls until rsp_tready returns
module spi_adc_frame_sequencer_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [sfs_pkg::REQ_W-1:0]  req_tdata,   // command[15:0], sample[27:16], zero pad
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [sfs_pkg::RSP_W-1:0]  rsp_tdata,   // tag[3:0], reading[15:4]
   output logic                       rsp_tuser,   // bad_command[0]
   input  logic                       csr_we,
   input  logic [sfs_pkg::GPIO_W-1:0] csr_wdata
);
   import sfs_pkg::*;

   req_word_type req_word;
   req_word_type word;
   logic         word_valid;
   logic         take;
   rsp_word_type rsp_word;

   assign req_word.command = req_tdata[CMD_W-1:0];
   assign req_word.sample  = req_tdata[CMD_W+SAMPLE_W-1:CMD_W];

   sfs_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_word   (req_word),
      .take       (take),
      .word_valid (word_valid),
      .word       (word)
   );

   sfs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .word_valid (word_valid),
      .word       (word),
      .take       (take),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {rsp_word.reading, rsp_word.tag};
   assign rsp_tuser = rsp_word.bad_command;

   a_bad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad command word carries data");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !word_valid)
      else $error("pipeline not empty after reset");

   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> word_valid)
      else $error("accepted word lost in input register");

   a_take_drains : assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid)
      else $error("taken word gave no result");
endmodule

// ===== rtl/sfs_in_stage.sv =====
module sfs_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sfs_pkg::req_word_type req_word,
   input  logic                 take,
   output logic                 word_valid,
   output sfs_pkg::req_word_type word
);
   import sfs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;
endmodule

// ===== rtl/sfs_core.sv =====
module sfs_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [3:0]            csr_wdata,
   input  logic                  word_valid,
   input  sfs_pkg::req_word_type word,
   output logic                  take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sfs_pkg::rsp_word_type rsp_word
);
   import sfs_pkg::*;

   logic [GPIO_W-1:0] gpio_ff;
   logic [CHAN_W-1:0] sel_ff, sel_in;
   logic [CHAN_W-1:0] samp_ff;
   logic [1:0]        mode_ff, mode_in;
   flags_type         flags_ff, flags_in;
   logic [CHAN_W-1:0] end_ff, end_in;
   logic              out_valid_ff;
   rsp_word_type      out_ff, out_in;

   logic [3:0]        code;
   logic              is_mode;
   logic              good;
   logic              entered;
   logic [CHAN_W:0]   nxt;
   logic [CMD_W-1:0]  cmd;

   assign take = word_valid && (!out_valid_ff || rsp_ready);
   assign cmd  = word.command;
   assign code = cmd[15:12];

   always_comb begin
      is_mode  = code inside {CODE_MANUAL, CODE_AUTO1, CODE_AUTO2};
      good     = is_mode || (code inside {CODE_CONTINUE, CODE_PROG1, CODE_PROG2});
      entered  = is_mode && (mode_ff != code[1:0]);
      mode_in  = is_mode ? code[1:0] : mode_ff;
      flags_in = flags_ff;
      if (is_mode && cmd[11]) begin
         flags_in.reset_channel = cmd[10];
         flags_in.gpio_out      = cmd[4];
      end
      end_in = (code == CODE_PROG2) ? cmd[9:6] : end_ff;
      nxt    = {1'b0, sel_ff} + {{CHAN_W{1'b0}}, 1'b1};
      sel_in = sel_ff;
      if (mode_in == MODE_MANUAL) begin
         sel_in = cmd[10:7];
      end else if (mode_in == MODE_AUTO2) begin
         if (entered || flags_in.reset_channel || nxt >= {1'b0, end_in}) begin
            sel_in = '0;
         end else begin
            sel_in = nxt[CHAN_W-1:0];
         end
      end
      out_in.reading     = good ? word.sample : '0;
      out_in.tag         = !good ? '0 : (flags_in.gpio_out ? gpio_ff : samp_ff);
      out_in.bad_command = !good;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpio_ff      <= '0;
         sel_ff       <= '0;
         samp_ff      <= '0;
         mode_ff      <= MODE_MANUAL;
         flags_ff     <= '0;
         end_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            gpio_ff <= csr_wdata;
         end
         if (take && good) begin
            sel_ff   <= sel_in;
            samp_ff  <= sel_ff;
            mode_ff  <= mode_in;
            flags_ff <= flags_in;
            end_ff   <= end_in;
         end
         if (take) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;
endmodule
